FILE: sv/gzip_member_header_parser_defines.svh
// ----------------------------------------------------------------------------
// gzip member header parser assertion macros
// shared property wrappers, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef GZIP_MEMBER_HEADER_PARSER_DEFINES_SVH
`define GZIP_MEMBER_HEADER_PARSER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define GZHP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define GZHP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/gzhp_pkg.sv
// ----------------------------------------------------------------------------
// gzip member header parser package
// transaction payload types, parse state and header constants
// ----------------------------------------------------------------------------
package gzhp_pkg;

    localparam logic [7:0]  ID1_BYTE    = 8'h1F;
    localparam logic [7:0]  ID2_BYTE    = 8'h8B;
    localparam logic [7:0]  CM_DEFLATE  = 8'd8;
    localparam logic [7:0]  TAG_S       = 8'h73;
    localparam logic [7:0]  TAG_L       = 8'h6C;
    localparam int unsigned FIXED_LEN   = 10;
    localparam int unsigned CRC_LEN     = 2;
    localparam int unsigned F_HCRC_BIT  = 1;
    localparam int unsigned F_EXTRA_BIT = 2;
    localparam int unsigned F_NAME_BIT  = 3;
    localparam int unsigned F_CMNT_BIT  = 4;
    localparam logic [7:0]  F_RESERVED  = 8'hE0;
    localparam int unsigned COUNT_W     = 20;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_FIXED   = 4'd1,
        PH_XLEN    = 4'd2,
        PH_EXTRA   = 4'd3,
        PH_NAME    = 4'd4,
        PH_COMMENT = 4'd5,
        PH_HCRC    = 4'd6
    } phase_t;

    typedef enum logic [2:0] {
        ST_IN_HEADER = 3'd0,
        ST_DONE_OK   = 3'd1,
        ST_BAD_MAGIC = 3'd2,
        ST_RESERVED  = 3'd3,
        ST_IDLE      = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        TAG_NONE = 2'd0,
        TAG_GOT_S  = 2'd1,
        TAG_GOT_SL = 2'd2,
        TAG_DONE   = 2'd3
    } tag_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_req;
    } item_t;

    typedef struct packed {
        status_t              status;
        logic [COUNT_W-1:0]   header_bytes;
        logic [31:0]          stored_comp_size;
        logic [31:0]          stored_uncomp_size;
        logic                 sl_found;
    } result_t;

    typedef struct packed {
        phase_t             phase;
        logic [15:0]        phase_count;
        logic [7:0]         flag_byte;
        logic               magic_ok;
        logic [15:0]        extra_length;
        logic [COUNT_W-1:0] header_count;
        logic [31:0]        comp_size;
        logic [31:0]        uncomp_size;
        tag_t               tag_seen;
    } state_t;

    localparam state_t STATE_RESET = '{
        phase:        PH_IDLE,
        phase_count:  16'd0,
        flag_byte:    8'd0,
        magic_ok:     1'b1,
        extra_length: 16'd0,
        header_count: '0,
        comp_size:    32'd0,
        uncomp_size:  32'd0,
        tag_seen:     TAG_NONE
    };

endpackage

FILE: sv/gzhp_step.sv
// ----------------------------------------------------------------------------
// gzip member header parser byte step
// next parse state and result fields for one header byte
// ----------------------------------------------------------------------------
module gzhp_step
(
    input  gzhp_pkg::state_t  state,
    input  gzhp_pkg::item_t   item,
    output gzhp_pkg::state_t  state_next,
    output gzhp_pkg::result_t res
);
    import gzhp_pkg::*;

    state_t      cur;
    state_t      nxt;
    status_t     st;
    logic [15:0] idx;
    logic [16:0] idx_inc;
    logic [15:0] xlen;
    logic [1:0]  lane;
    logic [31:0] lane_bits;
    logic        magic;
    logic        active;

    // next selected optional part after the part just finished
    function automatic phase_t next_part(input phase_t done, input logic [7:0] flags);
        phase_t p;
        p = PH_IDLE;
        if (done < PH_HCRC && flags[F_HCRC_BIT])
            p = PH_HCRC;
        if (done < PH_COMMENT && flags[F_CMNT_BIT])
            p = PH_COMMENT;
        if (done < PH_NAME && flags[F_NAME_BIT])
            p = PH_NAME;
        if (done < PH_XLEN && flags[F_EXTRA_BIT])
            p = PH_XLEN;
        return p;
    endfunction

    function automatic status_t end_status(input phase_t p, input logic [7:0] flags);
        status_t s;
        if (p != PH_IDLE)
            s = ST_IN_HEADER;
        else if ((flags & F_RESERVED) != 8'd0)
            s = ST_RESERVED;
        else
            s = ST_DONE_OK;
        return s;
    endfunction

    always_comb
    begin
        if (item.start_req)
        begin
            cur       = STATE_RESET;
            cur.phase = PH_FIXED;
        end
        else
        begin
            cur = state;
        end
        idx     = cur.phase_count;
        idx_inc = {1'b0, idx} + 17'd1;
        // size bytes sit at offsets 2..5 and 6..9, both map to lanes via +2
        lane      = 2'(idx[1:0] + 2'd2);
        lane_bits = {24'd0, item.data_byte} << {lane, 3'b000};
        xlen      = cur.extra_length | {item.data_byte, 8'd0};
        magic     = cur.magic_ok &
                    !((idx == 16'd0 && item.data_byte != ID1_BYTE) ||
                      (idx == 16'd1 && item.data_byte != ID2_BYTE) ||
                      (idx == 16'd2 && item.data_byte != CM_DEFLATE));
        active    = (cur.phase == PH_FIXED) || (cur.phase == PH_XLEN) ||
                    (cur.phase == PH_EXTRA) || (cur.phase == PH_NAME) ||
                    (cur.phase == PH_COMMENT) || (cur.phase == PH_HCRC);

        nxt = cur;
        st  = ST_IDLE;
        if (active)
        begin
            if (cur.header_count != COUNT_MAX)
                nxt.header_count = cur.header_count + 1'b1;
            st = ST_IN_HEADER;
            unique case (cur.phase) inside
                PH_FIXED:
                begin
                    nxt.magic_ok = magic;
                    if (idx == 16'd3)
                        nxt.flag_byte = item.data_byte;
                    if (idx_inc >= 17'(FIXED_LEN))
                    begin
                        nxt.phase_count = 16'd0;
                        if (!magic)
                        begin
                            nxt.phase = PH_IDLE;
                            st        = ST_BAD_MAGIC;
                        end
                        else
                        begin
                            nxt.phase = next_part(PH_FIXED, nxt.flag_byte);
                            st        = end_status(nxt.phase, nxt.flag_byte);
                        end
                    end
                    else
                    begin
                        nxt.phase_count = idx_inc[15:0];
                    end
                end
                PH_XLEN:
                begin
                    if (idx == 16'd0)
                    begin
                        nxt.extra_length = {8'd0, item.data_byte};
                        nxt.phase_count  = 16'd1;
                    end
                    else
                    begin
                        nxt.extra_length = xlen;
                        nxt.phase_count  = 16'd0;
                        if (xlen == 16'd0)
                        begin
                            nxt.phase = next_part(PH_XLEN, cur.flag_byte);
                            st        = end_status(nxt.phase, cur.flag_byte);
                        end
                        else
                        begin
                            nxt.phase = PH_EXTRA;
                        end
                    end
                end
                PH_EXTRA:
                begin
                    if (idx == 16'd0)
                    begin
                        nxt.tag_seen = (item.data_byte == TAG_S) ? TAG_GOT_S : TAG_NONE;
                    end
                    else if (idx == 16'd1)
                    begin
                        nxt.tag_seen = (cur.tag_seen == TAG_GOT_S && item.data_byte == TAG_L)
                                       ? TAG_GOT_SL : TAG_NONE;
                    end
                    else if (idx < 16'd6 && cur.tag_seen == TAG_GOT_SL)
                    begin
                        nxt.comp_size = cur.comp_size | lane_bits;
                    end
                    else if (idx < 16'(FIXED_LEN) && cur.tag_seen == TAG_GOT_SL)
                    begin
                        nxt.uncomp_size = cur.uncomp_size | lane_bits;
                        if (idx == 16'(FIXED_LEN - 1))
                            nxt.tag_seen = TAG_DONE;
                    end
                    nxt.phase_count = idx_inc[15:0];
                    if (idx_inc >= {1'b0, cur.extra_length})
                    begin
                        nxt.phase       = next_part(PH_EXTRA, cur.flag_byte);
                        nxt.phase_count = 16'd0;
                        st              = end_status(nxt.phase, cur.flag_byte);
                    end
                end
                PH_NAME, PH_COMMENT:
                begin
                    // zero terminator ends the string and is counted
                    if (item.data_byte == 8'd0)
                    begin
                        nxt.phase       = next_part(cur.phase, cur.flag_byte);
                        nxt.phase_count = 16'd0;
                        st              = end_status(nxt.phase, cur.flag_byte);
                    end
                end
                PH_HCRC:
                begin
                    if (idx_inc >= 17'(CRC_LEN))
                    begin
                        nxt.phase       = next_part(PH_HCRC, cur.flag_byte);
                        nxt.phase_count = 16'd0;
                        st              = end_status(nxt.phase, cur.flag_byte);
                    end
                    else
                    begin
                        nxt.phase_count = idx_inc[15:0];
                    end
                end
                default:
                begin
                    nxt.phase = PH_IDLE;
                end
            endcase
        end
        else
        begin
            nxt.phase = PH_IDLE;
        end
    end

    assign state_next             = nxt;
    assign res.status             = st;
    assign res.header_bytes       = nxt.header_count;
    assign res.sl_found           = (nxt.tag_seen == TAG_DONE);
    assign res.stored_comp_size   = (nxt.tag_seen == TAG_DONE) ? nxt.comp_size : 32'd0;
    assign res.stored_uncomp_size = (nxt.tag_seen == TAG_DONE) ? nxt.uncomp_size : 32'd0;

endmodule

FILE: sv/gzip_member_header_parser.sv
// a byte accepted into the input register is stepped and its result is registered into the result register
// throughput: one byte per cycle while no finished result waits untaken; the parse state update is combinational
// the input register can take a new byte while a finished result waits, but the state update stalls until it is taken
// reset: asynchronous, parse state idle, magic flag set, counts and sizes zero
// ----------------------------------------------------------------------------
// gzip member header parser
// byte-wide header walker with input register, state update and result register
// ----------------------------------------------------------------------------
`include "gzip_member_header_parser_defines.svh"

module gzip_member_header_parser
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  gzhp_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output gzhp_pkg::result_t result
);
    import gzhp_pkg::*;

    logic    item_valid_reg;
    item_t   item_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t step_res;
    logic    result_valid_reg;
    result_t result_reg;
    logic    advance;

    assign advance    = item_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !item_valid_reg || advance;

    gzhp_step u_step
    (
        .state      (state_reg),
        .item       (item_reg),
        .state_next (state_next),
        .res        (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            state_reg        <= STATE_RESET;
        end
        else
        begin
            if (item_ready)
                item_valid_reg <= item_valid;
            if (advance)
            begin
                result_valid_reg <= 1'b1;
                state_reg        <= state_next;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            item_reg <= item;
        if (advance)
            result_reg <= step_res;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `GZHP_ASSERT_NEXT(a_advance_gives_result, advance, result_valid_reg, "transaction lost between stages")
    `GZHP_ASSERT_SAME(a_stall_only_on_full, !item_ready, item_valid_reg && result_valid_reg && !result_ready, "input stalled without a waiting result")
    `GZHP_ASSERT_SAME(a_idle_byte_status, advance && !item_reg.start_req && state_reg.phase == PH_IDLE, step_res.status == ST_IDLE, "idle byte reported as header byte")
    `GZHP_ASSERT_SAME(a_sl_needs_extra, state_reg.tag_seen == TAG_DONE, state_reg.flag_byte[F_EXTRA_BIT], "sl subfield without extra flag")

endmodule
